>>> hdl/kmp_pkg.sv
package kmp_pkg;

    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_TEXT    = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam int CFG_WIDTH = 7;

    typedef enum logic [1:0] {
        OP_PATTERN,
        OP_TEXT,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_FT   = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

endpackage

>>> hdl/kmp_ram.sv
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/kmp_front.sv
module kmp_front #(
    parameter int SYMBOL_WIDTH = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_kind,
    input  logic [7:0]              i_symbol,
    output kmp_pkg::t_qhead         o_head,
    output logic [SYMBOL_WIDTH-1:0] o_head_sym,
    input  logic                    i_pop
);

    localparam int SIW = (SYMBOL_WIDTH < 8) ? SYMBOL_WIDTH : 8;

    kmp_pkg::t_op          r_q_op  [2];
    logic [SYMBOL_WIDTH-1:0] r_q_sym [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  n_wp, n_rp;
    logic [1:0]            n_cnt;

    kmp_pkg::t_op          w_op;
    logic [SYMBOL_WIDTH-1:0] w_sym;
    logic                  w_push, w_pop;

    always_comb begin
        case (i_kind)
            kmp_pkg::KIND_PATTERN: w_op = kmp_pkg::OP_PATTERN;
            kmp_pkg::KIND_TEXT:    w_op = kmp_pkg::OP_TEXT;
            kmp_pkg::KIND_CLEAR:   w_op = kmp_pkg::OP_CLEAR;
            default:               w_op = kmp_pkg::OP_NONE;
        endcase
    end

    assign w_sym   = SYMBOL_WIDTH'(i_symbol[SIW-1:0]);
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_q_op[r_rp];
    assign o_head_sym   = r_q_sym[r_rp];

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wp]  <= w_op;
            r_q_sym[r_wp] <= w_sym;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/kmp_engine.sv
module kmp_engine #(
    parameter int PATTERN_MAX  = 64,
    parameter int SYMBOL_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [kmp_pkg::CFG_WIDTH-1:0] i_len_cfg,
    input  kmp_pkg::t_qhead               i_head,
    input  logic [SYMBOL_WIDTH-1:0]       i_head_sym,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_matched,
    output logic [31:0]                   o_match_start,
    output logic [31:0]                   o_match_count,
    output logic                          o_pattern_ready
);

    localparam int IW  = $clog2(PATTERN_MAX + 1);
    localparam int PAW = $clog2(PATTERN_MAX);
    localparam int LW  = (IW > kmp_pkg::CFG_WIDTH) ? IW : kmp_pkg::CFG_WIDTH;

    kmp_pkg::t_state r_state, n_state;
    kmp_pkg::t_op    r_op, n_op;
    logic [SYMBOL_WIDTH-1:0] r_sym, n_sym;
    logic [IW-1:0]   r_fill, n_fill;
    logic [IW-1:0]   r_prefix, n_prefix;
    logic [IW-1:0]   r_ml, n_ml;
    logic [IW-1:0]   r_j, n_j;
    logic [31:0]     r_tp, n_tp;
    logic [31:0]     r_count, n_count;

    logic            r_res_matched, r_res_ready;
    logic [31:0]     r_res_start, r_res_count;
    logic            r_out_valid, r_out_matched, r_out_ready;
    logic [31:0]     r_out_start, r_out_count;

    logic [LW-1:0]   w_cfg, w_pmax, w_eff;
    logic [IW-1:0]   w_len, w_j0, w_jn, w_rd_j;
    logic            w_out_free, w_eq, w_fin, w_load_fin, w_load_res;
    logic            f_matched, f_ready;
    logic [31:0]     f_start;

    logic                    ps_we;
    logic [SYMBOL_WIDTH-1:0] ps_q;
    logic                    ft_we;
    logic [IW-1:0]           ft_waddr, ft_wdata, ft_q;

    kmp_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(PATTERN_MAX)) u_pattern (
        .i_clk   (i_clk),
        .i_we    (ps_we),
        .i_waddr (r_fill[PAW-1:0]),
        .i_wdata (i_head_sym),
        .i_raddr (w_rd_j[PAW-1:0]),
        .o_rdata (ps_q)
    );

    kmp_ram #(.WIDTH(IW), .DEPTH(PATTERN_MAX + 1)) u_failure (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_waddr),
        .i_wdata (ft_wdata),
        .i_raddr (w_rd_j),
        .o_rdata (ft_q)
    );

    always_comb begin
        w_cfg  = LW'(i_len_cfg);
        w_pmax = LW'(PATTERN_MAX);
        if (w_cfg == '0) begin
            w_eff = LW'(1);
        end else if (w_cfg > w_pmax) begin
            w_eff = w_pmax;
        end else begin
            w_eff = w_cfg;
        end
        w_len = w_eff[IW-1:0];
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_j0       = (r_ml >= w_len) ? '0 : r_ml;
    assign w_eq       = (ps_q == r_sym);
    assign w_jn       = r_j + IW'(w_eq && (r_op != kmp_pkg::OP_PATTERN || r_j < r_fill));

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sym     = r_sym;
        n_fill    = r_fill;
        n_prefix  = r_prefix;
        n_ml      = r_ml;
        n_j       = r_j;
        n_tp      = r_tp;
        n_count   = r_count;
        w_rd_j    = r_j;
        o_pop     = 1'b0;
        ps_we     = 1'b0;
        ft_we     = 1'b0;
        ft_waddr  = r_fill + IW'(1);
        ft_wdata  = w_jn;
        w_fin     = 1'b0;
        f_matched = 1'b0;
        f_start   = '0;
        w_load_res = 1'b0;
        case (r_state)
            kmp_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_op  = i_head.op;
                    n_sym = i_head_sym;
                    case (i_head.op)
                        kmp_pkg::OP_CLEAR: begin
                            n_fill   = '0;
                            n_prefix = '0;
                            n_ml     = '0;
                            n_tp     = '0;
                            n_count  = '0;
                            w_fin    = 1'b1;
                        end
                        kmp_pkg::OP_PATTERN: begin
                            if (r_fill < w_len) begin
                                ps_we = 1'b1;
                                if (r_fill == '0) begin
                                    ft_we    = 1'b1;
                                    ft_waddr = IW'(1);
                                    ft_wdata = '0;
                                    n_prefix = '0;
                                    n_fill   = IW'(1);
                                    w_fin    = 1'b1;
                                end else begin
                                    w_rd_j  = r_prefix;
                                    n_j     = r_prefix;
                                    n_state = kmp_pkg::ST_LOOK;
                                end
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        kmp_pkg::OP_TEXT: begin
                            if (r_fill >= w_len) begin
                                w_rd_j  = w_j0;
                                n_j     = w_j0;
                                n_state = kmp_pkg::ST_LOOK;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            kmp_pkg::ST_LOOK: begin
                if (r_j != '0 && !w_eq) begin
                    n_j    = ft_q;
                    w_rd_j = ft_q;
                end else if (r_op == kmp_pkg::OP_PATTERN) begin
                    ft_we    = 1'b1;
                    n_prefix = w_jn;
                    n_fill   = r_fill + IW'(1);
                    w_fin    = 1'b1;
                end else if (w_jn >= w_len) begin
                    w_rd_j  = w_len;
                    n_state = kmp_pkg::ST_FT;
                end else begin
                    n_ml  = w_jn;
                    n_tp  = r_tp + 32'd1;
                    w_fin = 1'b1;
                end
            end
            kmp_pkg::ST_FT: begin
                n_ml      = ft_q;
                f_matched = 1'b1;
                f_start   = r_tp - 32'(w_len) + 32'd1;
                n_count   = r_count + 32'd1;
                n_tp      = r_tp + 32'd1;
                w_fin     = 1'b1;
            end
            kmp_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_load_res = 1'b1;
                    n_state    = kmp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kmp_pkg::ST_IDLE;
            end
        endcase
        f_ready    = (n_fill >= w_len);
        w_load_fin = w_fin && w_out_free;
        if (w_fin) begin
            n_state = w_out_free ? kmp_pkg::ST_IDLE : kmp_pkg::ST_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_sym <= n_sym;
        r_j   <= n_j;
        if (w_fin && !w_out_free) begin
            r_res_matched <= f_matched;
            r_res_start   <= f_start;
            r_res_count   <= n_count;
            r_res_ready   <= f_ready;
        end
        if (w_load_fin) begin
            r_out_matched <= f_matched;
            r_out_start   <= f_start;
            r_out_count   <= n_count;
            r_out_ready   <= f_ready;
        end else if (w_load_res) begin
            r_out_matched <= r_res_matched;
            r_out_start   <= r_res_start;
            r_out_count   <= r_res_count;
            r_out_ready   <= r_res_ready;
        end
        if (!i_rst_n) begin
            r_state     <= kmp_pkg::ST_IDLE;
            r_fill      <= '0;
            r_prefix    <= '0;
            r_ml        <= '0;
            r_tp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_prefix    <= n_prefix;
            r_ml        <= n_ml;
            r_tp        <= n_tp;
            r_count     <= n_count;
            r_out_valid <= (w_load_fin || w_load_res) ? 1'b1 :
                           (i_ready ? 1'b0 : r_out_valid);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_matched       = r_out_matched;
    assign o_match_start   = r_out_start;
    assign o_match_count   = r_out_count;
    assign o_pattern_ready = r_out_ready;

`ifndef SYNTHESIS
    a_look_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmp_pkg::ST_LOOK) |-> (r_j < r_fill))
        else $error("chain index not below pattern fill");

    a_prefix_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (r_prefix < r_fill))
        else $error("prefix length not below pattern fill");

    a_ft_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmp_pkg::ST_FT) |-> ($past(r_state) == kmp_pkg::ST_LOOK))
        else $error("failure fetch without a preceding match step");

    a_emit_waits_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmp_pkg::ST_EMIT) |-> r_out_valid)
        else $error("result parked while output register empty");
`endif

endmodule

>>> hdl/kmp_stream_matcher.sv
// KMP stream matcher.
// Input stream: s_axis_tuser is the request kind (pattern symbol, text symbol,
// clear), s_axis_tdata the symbol. Every accepted request gives exactly one
// result on the output stream: m_axis_tuser = {pattern_ready, matched},
// m_axis_tdata = {match_count, match_start}.
// pattern_length is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while no request is in flight (not enforced by the block).
// 0 acts as 1, values above PATTERN_MAX act as PATTERN_MAX. Requests pass
// through a two-entry queue to the match engine, which runs the failure
// chain against two block RAMs (pattern symbols, failure table). Clear,
// ignored requests and the first pattern symbol finish in the idle state;
// other pattern and text symbols go on to the look state, which repeats once
// per failure-chain step, and a full match adds the FT state to fetch the
// failure entry. The chain walk is one RAM read per cycle.
// Reset clears all match state and the queue and sets pattern_length to 1;
// the RAM contents are not cleared and are written before they are read.
// When m_axis_tready is low the result is held and the engine stalls once
// a second result is ready; the queue keeps taking requests until full.
module kmp_stream_matcher #(
    parameter int PATTERN_MAX  = 64,
    parameter int SYMBOL_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] match_start, [63:32] match_count
    output logic [1:0]  m_axis_tuser,   // [0] matched, [1] pattern_ready
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    logic [kmp_pkg::CFG_WIDTH-1:0] r_pattern_length;
    kmp_pkg::t_qhead               w_head;
    logic [SYMBOL_WIDTH-1:0]       w_head_sym;
    logic                          w_pop;
    logic                          w_matched, w_ready;
    logic [31:0]                   w_start, w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= kmp_pkg::CFG_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_pattern_length <= i_cfg_wdata;
        end
    end

    kmp_front #(.SYMBOL_WIDTH(SYMBOL_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_symbol   (s_axis_tdata),
        .o_head     (w_head),
        .o_head_sym (w_head_sym),
        .i_pop      (w_pop)
    );

    kmp_engine #(.PATTERN_MAX(PATTERN_MAX), .SYMBOL_WIDTH(SYMBOL_WIDTH)) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len_cfg       (r_pattern_length),
        .i_head          (w_head),
        .i_head_sym      (w_head_sym),
        .o_pop           (w_pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_matched       (w_matched),
        .o_match_start   (w_start),
        .o_match_count   (w_count),
        .o_pattern_ready (w_ready)
    );

    assign m_axis_tdata = {w_count, w_start};
    assign m_axis_tuser = {w_ready, w_matched};

endmodule

>>> tb/kmp_scoreboard.sv
package kmp_tb_pkg;

    import kmp_pkg::*;

    class kmp_scoreboard;

        localparam int PAT_MAX = 64;

        typedef struct packed {
            logic        matched;
            logic [31:0] match_start;
            logic [31:0] match_count;
            logic        pattern_ready;
        } t_match_report;

        logic [7:0]    pat_sym [PAT_MAX];
        logic [6:0]    fail_len [PAT_MAX + 1];
        logic [6:0]    pat_fill;
        logic [6:0]    prefix_len;
        logic [6:0]    cur_len;
        logic [6:0]    length_reg;
        logic [31:0]   text_pos;
        logic [31:0]   hits;
        t_match_report match_reports[$];
        int            errors;
        int            checked;

        function new();
            length_reg = 7'd1;
            errors     = 0;
            checked    = 0;
            restart();
        endfunction

        function void restart();
            pat_fill   = '0;
            prefix_len = '0;
            cur_len    = '0;
            text_pos   = '0;
            hits       = '0;
        endfunction

        function void set_length(logic [6:0] value);
            length_reg = value;
        endfunction

        function int effective_length();
            if (length_reg == 0) begin
                return 1;
            end
            if (length_reg > PAT_MAX) begin
                return PAT_MAX;
            end
            return int'(length_reg);
        endfunction

        function int results_due();
            return match_reports.size();
        endfunction

        // Runs one accepted request through the KMP state and queues its result.
        function void note_request(t_op kind, logic [7:0] sym);
            t_match_report want;
            int            len;
            int            i;
            int            j;
            want = '0;
            len  = effective_length();
            case (kind)
                OP_CLEAR: begin
                    restart();
                end
                OP_PATTERN: begin
                    if (pat_fill < len) begin
                        i = int'(pat_fill);
                        pat_sym[i] = sym;
                        if (i == 0) begin
                            fail_len[0] = '0;
                            fail_len[1] = '0;
                            prefix_len  = '0;
                        end else begin
                            j = int'(prefix_len);
                            while (j > 0 && pat_sym[j] != sym) begin
                                j = int'(fail_len[j]);
                            end
                            if (j < i && pat_sym[j] == sym) begin
                                j++;
                            end
                            fail_len[i + 1] = 7'(j);
                            prefix_len      = 7'(j);
                        end
                        pat_fill = 7'(i + 1);
                    end
                end
                OP_TEXT: begin
                    if (pat_fill >= len) begin
                        j = int'(cur_len);
                        if (j >= len) begin
                            j = 0;
                        end
                        while (j > 0 && pat_sym[j] != sym) begin
                            j = int'(fail_len[j]);
                        end
                        if (pat_sym[j] == sym) begin
                            j++;
                        end
                        if (j >= len) begin
                            want.matched     = 1'b1;
                            want.match_start = text_pos - 32'(len) + 32'd1;
                            hits             = hits + 32'd1;
                            j                = int'(fail_len[len]);
                        end
                        cur_len  = 7'(j);
                        text_pos = text_pos + 32'd1;
                    end
                end
                default: begin
                end
            endcase
            want.match_count   = hits;
            want.pattern_ready = (pat_fill >= effective_length());
            match_reports.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 200) begin
                $display("MISMATCH result %0d: %s", checked, msg);
            end
            errors++;
        endtask

        task check_result(logic [63:0] data, logic [1:0] flags);
            t_match_report want;
            if (match_reports.size() == 0) begin
                report($sformatf("no request waiting, data=%h flags=%b", data, flags));
                checked++;
                return;
            end
            want = match_reports.pop_front();
            if (flags[0] !== want.matched) begin
                report($sformatf("matched %b, want %b", flags[0], want.matched));
            end
            if (data[31:0] !== want.match_start) begin
                report($sformatf("match_start %0d, want %0d", data[31:0], want.match_start));
            end
            if (data[63:32] !== want.match_count) begin
                report($sformatf("match_count %0d, want %0d", data[63:32], want.match_count));
            end
            if (flags[1] !== want.pattern_ready) begin
                report($sformatf("pattern_ready %b, want %b", flags[1], want.pattern_ready));
            end
            checked++;
        endtask

    endclass

endpackage

>>> tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import kmp_pkg::*;
    import kmp_tb_pkg::*;

    localparam int ITEMS_TARGET = 1900;
    localparam int TAIL_START   = 1700;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we      = 1'b0;
    logic [6:0]  i_cfg_wdata   = '0;

    kmp_scoreboard sb = new();

    int         sent_total   = 0;
    bit         src_idle_on  = 1'b0;
    bit         sink_idle_on = 1'b0;
    int         stall_left   = 0;
    logic [7:0] pat_now[$];
    logic [7:0] alphabet[3];
    int         alpha_n      = 1;

    kmp_stream_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_req(input t_op kind, input logic [7:0] sym);
        int gap;
        if (sent_total >= TAIL_START) begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
        end
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= sym;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, sym);
        if (kind != OP_NONE) begin
            sent_total++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.results_due() != 0) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [6:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_length(value);
    endtask

    function automatic logic [6:0] pick_length();
        logic [6:0] edges[5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
        case ($urandom_range(0, 9))
            0: return edges[$urandom_range(0, 4)];
            1: return 7'($urandom_range(7, 64));
            default: return 7'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_noise();
        logic [7:0] sym;
        sym = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: send_req(OP_CLEAR, sym);
            1, 2, 3: send_req(OP_NONE, sym);
            4, 5: send_req(OP_PATTERN, sym);
            default: send_req(OP_TEXT, sym);
        endcase
    endtask

    task automatic load_pattern(input int eff);
        logic [7:0] sym;
        while (pat_now.size() < eff) begin
            sym = alphabet[$urandom_range(0, alpha_n - 1)];
            send_req(OP_PATTERN, sym);
            pat_now.push_back(sym);
        end
    endtask

    // text of pattern copies and prefixes, lone symbols and noise, so matches can overlap
    task automatic stream_text(input int n_items);
        int k;
        int cut;
        k = 0;
        while (k < n_items) begin
            case ($urandom_range(0, 3))
                0, 1: cut = pat_now.size();
                2: cut = (pat_now.size() == 0) ? 0 : $urandom_range(1, pat_now.size());
                default: cut = 0;
            endcase
            if (cut == 0) begin
                send_req(OP_TEXT, alphabet[$urandom_range(0, alpha_n - 1)]);
                k++;
            end
            for (int m = 0; m < cut; m++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_noise();
                end
                send_req(OP_TEXT, pat_now[m]);
            end
            k += cut;
        end
    endtask

    task automatic search_phase();
        int eff;
        drain();
        src_idle_on  = (sent_total < TAIL_START) && ($urandom_range(0, 2) != 0);
        sink_idle_on = (sent_total < TAIL_START) && ($urandom_range(0, 2) != 0);
        write_length(pick_length());
        send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
        pat_now.delete();
        alpha_n = $urandom_range(1, 3);
        foreach (alphabet[a]) alphabet[a] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) begin
            send_req(OP_TEXT, alphabet[0]);
        end
        load_pattern(sb.effective_length());
        if ($urandom_range(0, 5) == 0) begin
            send_req(OP_PATTERN, 8'($urandom_range(0, 255)));
        end
        stream_text($urandom_range(10, 60));
        if ($urandom_range(0, 4) == 0) begin
            // length change without clear
            drain();
            write_length(pick_length());
            eff = sb.effective_length();
            while (pat_now.size() > eff) void'(pat_now.pop_back());
            load_pattern(eff);
            stream_text($urandom_range(10, 40));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length 1 after reset, then lengths 0, 2, 127 and 1
        send_req(OP_TEXT, 8'h5A);
        send_req(OP_NONE, 8'hFF);
        send_req(OP_PATTERN, 8'hFF);
        send_req(OP_TEXT, 8'hFF);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'hFF);
        send_req(OP_PATTERN, 8'h00);
        send_req(OP_CLEAR, 8'hA5);
        drain();
        write_length(7'd0);
        send_req(OP_PATTERN, 8'h00);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'h00);
        drain();
        write_length(7'd2);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_PATTERN, 8'h00);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'h00);
        drain();
        write_length(7'd127);
        send_req(OP_PATTERN, 8'h00);
        send_req(OP_TEXT, 8'h00);
        drain();
        write_length(7'd1);
        send_req(OP_TEXT, 8'h00);
        send_req(OP_TEXT, 8'h01);

        while (sent_total < ITEMS_TARGET) search_phase();

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[kmp_stream_matcher] OK");
        end else begin
            $display("[kmp_stream_matcher] ERROR");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("[kmp_stream_matcher] ERROR");
        $finish;
    end

endmodule
